>>> design/rtdt_pkg.sv
// ----------------------------------------------------------------------------
// rtdt_pkg
// Shared constants, field layouts and inter-module structs for the runaway
// thread detect table.
// ----------------------------------------------------------------------------
package rtdt_pkg;

    // table and list geometry (TABLE_SIZE must be a power of two)
    localparam int TABLE_SIZE = 256;
    localparam int LIST_DEPTH = 256;
    localparam int SLOT_AW    = $clog2(TABLE_SIZE);
    localparam int LIST_AW    = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int LIST_CW    = $clog2(LIST_DEPTH + 1);

    // field widths
    localparam int KIND_W     = 3;
    localparam int TID_W      = 31;
    localparam int CPU_W      = 63;
    localparam int PRIO_W     = 7;
    localparam int TEAM_W     = 31;
    localparam int EIDX_W     = 8;
    localparam int SAMPLE_W   = 8;
    localparam int CNT_W      = 9;
    localparam int SAMPLE_LSB = 11;   // cpu time in units of 2048 us

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 31;

    localparam logic [TID_W-1:0]    OWN_THREAD_RST  = '0;
    localparam logic [PRIO_W-1:0]   MIN_PRIO_RST    = 7'd10;
    localparam logic [SAMPLE_W-1:0] JUMP_THRESH_RST = 8'd25;

    // input tdata layout, lowest bit first
    localparam int IN_THREAD_LSB = 0;
    localparam int IN_CPU_LSB    = IN_THREAD_LSB + TID_W;
    localparam int IN_PRIO_LSB   = IN_CPU_LSB + CPU_W;
    localparam int IN_TEAM_LSB   = IN_PRIO_LSB + PRIO_W;
    localparam int IN_EIDX_LSB   = IN_TEAM_LSB + TEAM_W;
    localparam int IN_FIELDS_W   = IN_EIDX_LSB + EIDX_W;
    localparam int IN_DATA_W     = ((IN_FIELDS_W + 7) / 8) * 8;

    // output tdata layout, lowest bit first
    localparam int OUT_FLAGGED_LSB = 0;
    localparam int OUT_FULL_LSB    = 1;
    localparam int OUT_LISTED_LSB  = 2;
    localparam int OUT_COUNT_LSB   = 3;
    localparam int OUT_THREAD_LSB  = OUT_COUNT_LSB + CNT_W;
    localparam int OUT_PRIO_LSB    = OUT_THREAD_LSB + TID_W;
    localparam int OUT_TEAM_LSB    = OUT_PRIO_LSB + PRIO_W;
    localparam int OUT_EVALID_LSB  = OUT_TEAM_LSB + TEAM_W;
    localparam int OUT_FIELDS_W    = OUT_EVALID_LSB + 1;
    localparam int OUT_DATA_W      = ((OUT_FIELDS_W + 7) / 8) * 8;

    typedef enum logic [KIND_W-1:0] {
        KIND_CLEAR  = 3'd0,
        KIND_RECORD = 3'd1,
        KIND_CHECK  = 3'd2,
        KIND_QUERY  = 3'd3,
        KIND_READ   = 3'd4
    } t_kind;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_OWN_THREAD  = 2'd0,
        CFG_MIN_PRIO    = 2'd1,
        CFG_JUMP_THRESH = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic [TID_W-1:0]    own_thread;
        logic [PRIO_W-1:0]   min_prio;
        logic [SAMPLE_W-1:0] jump_thresh;
    } t_cfg;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [TID_W-1:0]  thread;
        logic [CPU_W-1:0]  cpu;
        logic [PRIO_W-1:0] prio;
        logic [TEAM_W-1:0] team;
        logic [EIDX_W-1:0] eidx;
    } t_item;

    typedef struct packed {
        logic              flagged;
        logic              table_full;
        logic              team_listed;
        logic [CNT_W-1:0]  count;
        logic [TID_W-1:0]  out_thread;
        logic [PRIO_W-1:0] out_prio;
        logic [TEAM_W-1:0] out_team;
        logic              entry_valid;
    } t_result;

    // slot table access
    typedef struct packed {
        logic                clear;
        logic                wr_en;
        logic [SLOT_AW-1:0]  wr_addr;
        logic [SLOT_AW-1:0]  rd_addr;
        logic [TID_W-1:0]    wr_thread;
        logic [SAMPLE_W-1:0] wr_sample;
    } t_slot_req;

    typedef struct packed {
        logic                used;
        logic [TID_W-1:0]    thread;
        logic [SAMPLE_W-1:0] sample;
    } t_slot_rsp;

    // flagged list access
    typedef struct packed {
        logic               wr_en;
        logic [LIST_AW-1:0] wr_addr;
        logic [LIST_AW-1:0] rd_addr;
        logic [TID_W-1:0]   wr_thread;
        logic [PRIO_W-1:0]  wr_prio;
        logic [TEAM_W-1:0]  wr_team;
    } t_list_req;

    typedef struct packed {
        logic [TID_W-1:0]  thread;
        logic [PRIO_W-1:0] prio;
        logic [TEAM_W-1:0] team;
    } t_list_rsp;

endpackage

>>> design/rtdt_slot_mem.sv
// ----------------------------------------------------------------------------
// rtdt_slot_mem
// Hash slot storage: thread id and time sample per slot, one write and one
// registered read per cycle, with a used bit per slot that clears at once.
// ----------------------------------------------------------------------------
module rtdt_slot_mem
    import rtdt_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_slot_req i_req,
    output t_slot_rsp o_rsp
);

    logic [TID_W+SAMPLE_W-1:0] r_mem [TABLE_SIZE];
    logic [TABLE_SIZE-1:0]     r_used;
    logic [TID_W+SAMPLE_W-1:0] r_rd_data;
    logic                      r_rd_used;

    // slot data array, read data registered
    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= {i_req.wr_thread, i_req.wr_sample};
        end
        r_rd_data <= r_mem[i_req.rd_addr];
        r_rd_used <= r_used[i_req.rd_addr];
    end

    // occupancy bits, cleared by reset or a clear item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0;
        end else if (i_req.clear) begin
            r_used <= '0;
        end else if (i_req.wr_en) begin
            r_used[i_req.wr_addr] <= 1'b1;
        end
    end

    assign o_rsp.used   = r_rd_used;
    assign o_rsp.thread = r_rd_data[SAMPLE_W +: TID_W];
    assign o_rsp.sample = r_rd_data[SAMPLE_W-1:0];

endmodule

>>> design/rtdt_list_mem.sv
// ----------------------------------------------------------------------------
// rtdt_list_mem
// Flagged thread list storage: thread, priority and team per entry, one
// write and one registered read per cycle.
// ----------------------------------------------------------------------------
module rtdt_list_mem
    import rtdt_pkg::*;
(
    input  logic      i_clk,
    input  t_list_req i_req,
    output t_list_rsp o_rsp
);

    t_list_rsp r_mem [LIST_DEPTH];
    t_list_rsp r_rd_data;

    // entry array, read data registered
    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= '{thread: i_req.wr_thread,
                                      prio:   i_req.wr_prio,
                                      team:   i_req.wr_team};
        end
        r_rd_data <= r_mem[i_req.rd_addr];
    end

    assign o_rsp = r_rd_data;

endmodule

>>> design/rtdt_seq.sv
// ----------------------------------------------------------------------------
// rtdt_seq
// Item sequencer: walks the probe chain of the slot table or the entries of
// the flagged list one per cycle through a single shared id comparator, then
// loads the result register.
// ----------------------------------------------------------------------------
module rtdt_seq
    import rtdt_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cfg      i_cfg,
    input  logic      i_item_valid,
    output logic      o_item_ready,
    input  t_item     i_item,
    output logic      o_res_valid,
    input  logic      i_res_ready,
    output t_result   o_res,
    output t_slot_req o_slot_req,
    input  t_slot_rsp i_slot_rsp,
    output t_list_req o_list_req,
    input  t_list_rsp i_list_rsp
);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_PROBE = 6'b000010,
        S_EVAL  = 6'b000100,
        S_SCAN  = 6'b001000,
        S_READ  = 6'b010000,
        S_FIN   = 6'b100000
    } t_state;

    t_state              r_state,  n_state;
    t_item               r_item,   n_item;
    logic [SAMPLE_W-1:0] r_sample, n_sample;
    logic [SAMPLE_W-1:0] r_stored, n_stored;
    logic [SLOT_AW-1:0]  r_idx,    n_idx;
    logic [SLOT_AW-1:0]  r_pcnt,   n_pcnt;
    logic [LIST_CW-1:0]  r_lidx,   n_lidx;
    logic [LIST_CW-1:0]  r_count,  n_count;
    t_result             r_res,    n_res;
    t_result             r_out,    n_out;
    logic                r_ovalid, n_ovalid;

    logic [TID_W-1:0]    cmp_a;
    logic [TID_W-1:0]    cmp_b;
    logic                cmp_eq;
    logic [SLOT_AW-1:0]  idx_nxt;
    logic [SLOT_AW-1:0]  home_idx;
    logic [LIST_CW-1:0]  lidx_nxt;
    logic [SAMPLE_W-1:0] delta;
    logic                ignored;

    // time sample: bits 18..11 of the cpu time, never zero
    function automatic logic [SAMPLE_W-1:0] make_sample(input logic [CPU_W-1:0] cpu);
        logic [SAMPLE_W-1:0] s;
        s = cpu[SAMPLE_LSB +: SAMPLE_W];
        return (s == '0) ? SAMPLE_W'(1) : s;
    endfunction

    // shared id comparator: slot thread during probe, list team during scan
    assign cmp_a  = (r_state == S_SCAN) ? i_list_rsp.team : i_slot_rsp.thread;
    assign cmp_b  = (r_state == S_SCAN) ? r_item.team     : r_item.thread;
    assign cmp_eq = (cmp_a == cmp_b);

    assign idx_nxt  = (r_idx == SLOT_AW'(TABLE_SIZE - 1)) ? '0 : r_idx + 1'b1;
    assign home_idx = SLOT_AW'(i_item.thread % TABLE_SIZE);
    assign lidx_nxt = r_lidx + 1'b1;
    assign delta    = r_sample - r_stored;
    assign ignored  = (i_item.thread == i_cfg.own_thread) || (i_item.prio <= i_cfg.min_prio);

    // next state and datapath
    always_comb begin
        n_state  = r_state;
        n_item   = r_item;
        n_sample = r_sample;
        n_stored = r_stored;
        n_idx    = r_idx;
        n_pcnt   = r_pcnt;
        n_lidx   = r_lidx;
        n_count  = r_count;
        n_res    = r_res;
        n_out    = r_out;
        n_ovalid = r_ovalid;

        o_slot_req           = '0;
        o_slot_req.rd_addr   = r_idx;
        o_slot_req.wr_addr   = r_idx;
        o_slot_req.wr_thread = r_item.thread;
        o_slot_req.wr_sample = r_sample;

        o_list_req           = '0;
        o_list_req.rd_addr   = r_lidx[LIST_AW-1:0];
        o_list_req.wr_addr   = r_count[LIST_AW-1:0];
        o_list_req.wr_thread = r_item.thread;
        o_list_req.wr_prio   = r_item.prio;
        o_list_req.wr_team   = r_item.team;

        if (r_ovalid && i_res_ready) begin
            n_ovalid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                o_slot_req.rd_addr = home_idx;
                o_list_req.rd_addr = (i_item.kind == KIND_READ) ?
                                     LIST_AW'(i_item.eidx) : '0;
                if (i_item_valid) begin
                    n_item   = i_item;
                    n_sample = make_sample(i_item.cpu);
                    n_res    = '0;
                    n_idx    = home_idx;
                    n_pcnt   = '0;
                    n_lidx   = '0;
                    case (i_item.kind)
                        KIND_CLEAR: begin
                            o_slot_req.clear = 1'b1;
                            n_count          = '0;
                            n_state          = S_FIN;
                        end
                        KIND_RECORD, KIND_CHECK: begin
                            n_state = ignored ? S_FIN : S_PROBE;
                        end
                        KIND_QUERY: begin
                            n_state = (r_count == '0) ? S_FIN : S_SCAN;
                        end
                        KIND_READ: begin
                            n_state = S_READ;
                        end
                        default: begin
                            n_state = S_FIN;
                        end
                    endcase
                end
            end

            // one slot per cycle along the probe chain
            S_PROBE: begin
                if (!i_slot_rsp.used || cmp_eq) begin
                    if (r_item.kind == KIND_RECORD) begin
                        o_slot_req.wr_en = 1'b1;
                        n_state          = S_FIN;
                    end else if (!i_slot_rsp.used) begin
                        n_state = S_FIN;
                    end else begin
                        n_stored = i_slot_rsp.sample;
                        n_state  = S_EVAL;
                    end
                end else if (r_pcnt == SLOT_AW'(TABLE_SIZE - 1)) begin
                    n_res.table_full = 1'b1;
                    n_state          = S_FIN;
                end else begin
                    n_idx              = idx_nxt;
                    n_pcnt             = r_pcnt + 1'b1;
                    o_slot_req.rd_addr = idx_nxt;
                end
            end

            // wrapped delta against the threshold, append when flagged and the list has room
            S_EVAL: begin
                if (delta > i_cfg.jump_thresh) begin
                    n_res.flagged = 1'b1;
                    if (r_count < LIST_CW'(LIST_DEPTH)) begin
                        o_list_req.wr_en = 1'b1;
                        n_count          = r_count + 1'b1;
                    end
                end
                n_state = S_FIN;
            end

            // one list entry per cycle looking for the team
            S_SCAN: begin
                if (cmp_eq) begin
                    n_res.team_listed = 1'b1;
                    n_state           = S_FIN;
                end else if (lidx_nxt >= r_count) begin
                    n_state = S_FIN;
                end else begin
                    n_lidx             = lidx_nxt;
                    o_list_req.rd_addr = lidx_nxt[LIST_AW-1:0];
                end
            end

            S_READ: begin
                if ({{LIST_CW{1'b0}}, r_item.eidx} < {{EIDX_W{1'b0}}, r_count}) begin
                    n_res.out_thread  = i_list_rsp.thread;
                    n_res.out_prio    = i_list_rsp.prio;
                    n_res.out_team    = i_list_rsp.team;
                    n_res.entry_valid = 1'b1;
                end
                n_state = S_FIN;
            end

            // hand the result over once the output register is free
            S_FIN: begin
                if (!r_ovalid || i_res_ready) begin
                    n_out       = r_res;
                    n_out.count = CNT_W'(r_count);
                    n_ovalid    = 1'b1;
                    n_state     = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_ovalid <= n_ovalid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_item   <= n_item;
        r_sample <= n_sample;
        r_stored <= n_stored;
        r_idx    <= n_idx;
        r_pcnt   <= n_pcnt;
        r_lidx   <= n_lidx;
        r_res    <= n_res;
        r_out    <= n_out;
    end

    assign o_item_ready = (r_state == S_IDLE);
    assign o_res_valid  = r_ovalid;
    assign o_res        = r_out;

endmodule

>>> design/runaway_thread_detect_table.sv
// ----------------------------------------------------------------------------
// runaway_thread_detect_table
// Thread cpu-time table with linear probing and a bounded list of threads
// whose time jumped past a threshold.
// ----------------------------------------------------------------------------
// One item is in work at a time and each gives one result item. A clear, an
// ignored record or check and an unused kind go straight to the result
// state, a list read through a read state; a record or check probes from the
// home slot (up to TABLE_SIZE slots), a check then evaluates a found thread;
// a team query scans the list (up to the list count). The walks are set by
// the single read ports of the slot memory and the list memory, each walked
// one address a cycle. The slot table starts empty out of reset with no
// clearing pass; a clear item empties it and the list. Configuration writes
// are registered and belong to idle periods.
module runaway_thread_detect_table
    import rtdt_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // input items
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    // thread_ident, cpu_time, thread_priority, team_ident, entry_index, zero pad
    input  logic [IN_DATA_W-1:0]  i_s_axis_tdata,
    // kind
    input  logic [KIND_W-1:0]     i_s_axis_tuser,
    // result items
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    // flagged, table_full, team_listed, flagged_count, out_thread,
    // out_priority, out_team, entry_valid, zero pad
    output logic [OUT_DATA_W-1:0] o_m_axis_tdata,
    // configuration writes
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg      r_cfg, n_cfg;
    t_item     item;
    t_result   res;
    t_slot_req slot_req;
    t_slot_rsp slot_rsp;
    t_list_req list_req;
    t_list_rsp list_rsp;

    // configuration registers
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_OWN_THREAD:  n_cfg.own_thread  = i_cfg_data[TID_W-1:0];
                CFG_MIN_PRIO:    n_cfg.min_prio    = i_cfg_data[PRIO_W-1:0];
                CFG_JUMP_THRESH: n_cfg.jump_thresh = i_cfg_data[SAMPLE_W-1:0];
                default:         n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{own_thread:  OWN_THREAD_RST,
                       min_prio:    MIN_PRIO_RST,
                       jump_thresh: JUMP_THRESH_RST};
        end else begin
            r_cfg <= n_cfg;
        end
    end

    // unpack the input item
    assign item.kind   = i_s_axis_tuser;
    assign item.thread = i_s_axis_tdata[IN_THREAD_LSB +: TID_W];
    assign item.cpu    = i_s_axis_tdata[IN_CPU_LSB +: CPU_W];
    assign item.prio   = i_s_axis_tdata[IN_PRIO_LSB +: PRIO_W];
    assign item.team   = i_s_axis_tdata[IN_TEAM_LSB +: TEAM_W];
    assign item.eidx   = i_s_axis_tdata[IN_EIDX_LSB +: EIDX_W];

    rtdt_seq u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_item_valid (i_s_axis_tvalid),
        .o_item_ready (o_s_axis_tready),
        .i_item       (item),
        .o_res_valid  (o_m_axis_tvalid),
        .i_res_ready  (i_m_axis_tready),
        .o_res        (res),
        .o_slot_req   (slot_req),
        .i_slot_rsp   (slot_rsp),
        .o_list_req   (list_req),
        .i_list_rsp   (list_rsp)
    );

    rtdt_slot_mem u_slot_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (slot_req),
        .o_rsp   (slot_rsp)
    );

    rtdt_list_mem u_list_mem (
        .i_clk (i_clk),
        .i_req (list_req),
        .o_rsp (list_rsp)
    );

    // pack the result item
    always_comb begin
        o_m_axis_tdata                                   = '0;
        o_m_axis_tdata[OUT_FLAGGED_LSB]                  = res.flagged;
        o_m_axis_tdata[OUT_FULL_LSB]                     = res.table_full;
        o_m_axis_tdata[OUT_LISTED_LSB]                   = res.team_listed;
        o_m_axis_tdata[OUT_COUNT_LSB +: CNT_W]           = res.count;
        o_m_axis_tdata[OUT_THREAD_LSB +: TID_W]          = res.out_thread;
        o_m_axis_tdata[OUT_PRIO_LSB +: PRIO_W]           = res.out_prio;
        o_m_axis_tdata[OUT_TEAM_LSB +: TEAM_W]           = res.out_team;
        o_m_axis_tdata[OUT_EVALID_LSB]                   = res.entry_valid;
    end

endmodule

>>> design/rtdt_chk.sv
// ----------------------------------------------------------------------------
// rtdt_chk
// Port-level checks for the runaway thread detect table, bound to the top.
// ----------------------------------------------------------------------------
module rtdt_chk
    import rtdt_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_s_axis_tvalid,
    input logic                  o_s_axis_tready,
    input logic                  o_m_axis_tvalid,
    input logic                  i_m_axis_tready,
    input logic [OUT_DATA_W-1:0] o_m_axis_tdata
);

    // an accepted item keeps the block busy for at least the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> !o_s_axis_tready)
        else $error("ready did not drop after an accepted item");

    // a stalled result holds
    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("stalled result item changed");

    // a valid list read implies a non-empty list
    a_read_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tdata[OUT_EVALID_LSB] |->
            o_m_axis_tdata[OUT_COUNT_LSB +: CNT_W] != '0)
        else $error("entry valid with an empty list");

    // a flagged check carries no query, read or full indication
    a_flag_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tdata[OUT_FLAGGED_LSB] |->
            !o_m_axis_tdata[OUT_FULL_LSB] && !o_m_axis_tdata[OUT_LISTED_LSB] &&
            !o_m_axis_tdata[OUT_EVALID_LSB] &&
            o_m_axis_tdata[OUT_COUNT_LSB +: CNT_W] != '0 ||
            !o_m_axis_tdata[OUT_FULL_LSB] && !o_m_axis_tdata[OUT_LISTED_LSB] &&
            !o_m_axis_tdata[OUT_EVALID_LSB] &&
            o_m_axis_tdata[OUT_COUNT_LSB +: CNT_W] == CNT_W'(LIST_DEPTH))
        else $error("flagged result mixed with other indications");

endmodule

bind runaway_thread_detect_table rtdt_chk u_rtdt_chk (.*);

>>> dv/runaway_thread_detect_table_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// runaway_thread_detect_table_tb
// Self-checking bench for the runaway thread detect table. A scheduler queue
// of items and register writes feeds a stream driver; every accepted item is
// run through a behavioral copy of the slot table and flagged list, and each
// result item is compared field by field with the oldest prediction. Covers
// ignored threads, probe collisions and wrap, full table, full list, list
// reads in and out of range, team queries and several register settings.
// ----------------------------------------------------------------------------
module runaway_thread_detect_table_tb;
    import rtdt_pkg::*;

    localparam int IDLE_PCT = 21;
    localparam int POOL     = 16;
    localparam int TEAMS    = 6;
    localparam int SETTLE   = 4;
    localparam int TAIL     = 300;
    localparam int LIMIT    = 2_000_000;
    localparam logic [KIND_W-1:0] KIND_SPARE = 3'd5;   // first unused kind

    typedef enum logic [1:0] {
        STEP_ITEM,
        STEP_CFG,
        STEP_DRAIN
    } t_step_kind;

    typedef struct packed {
        t_step_kind            sk;
        t_item                 it;
        logic                  calm;
        t_cfg_idx              reg_idx;
        logic [CFG_DATA_W-1:0] reg_val;
    } t_step;

    logic                  i_clk    = 1'b0;
    logic                  i_rst_n  = 1'b0;
    logic                  s_valid  = 1'b0;
    logic [IN_DATA_W-1:0]  s_data   = '0;
    logic [KIND_W-1:0]     s_kind   = '0;
    logic                  m_ready  = 1'b0;
    logic                  cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx  = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  s_ready;
    logic                  m_valid;
    logic [OUT_DATA_W-1:0] m_data;

    // stimulus schedule and predictions still owed by the block
    t_step   schedule[$];
    t_result awaited[$];
    t_item   cur_item = '0;
    logic    calm_now = 1'b0;
    logic    gen_calm = 1'b0;
    logic [PRIO_W-1:0] gen_min = MIN_PRIO_RST;
    int      n_presented = 0;
    int      n_accepted  = 0;
    int      n_errors    = 0;
    int      n_results   = 0;
    int      n_flag_seen = 0;
    int      n_full_seen = 0;
    int      n_team_hits = 0;
    int      n_reads_ok  = 0;

    // behavioral copy of the table, the list and the registers
    logic [TID_W-1:0]    mdl_slot_tid  [TABLE_SIZE];
    logic [SAMPLE_W-1:0] mdl_slot_smp  [TABLE_SIZE];
    logic [TID_W-1:0]    mdl_list_tid  [LIST_DEPTH];
    logic [PRIO_W-1:0]   mdl_list_prio [LIST_DEPTH];
    logic [TEAM_W-1:0]   mdl_list_team [LIST_DEPTH];
    int                  mdl_count = 0;
    t_cfg                mdl_cfg = {OWN_THREAD_RST, MIN_PRIO_RST, JUMP_THRESH_RST};

    runaway_thread_detect_table DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tuser  (s_kind),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .i_cfg_we        (cfg_we),
        .i_cfg_idx       (cfg_idx),
        .i_cfg_data      (cfg_data)
    );

    always #1 i_clk = ~i_clk;

    // next detector verdict for one item, updating the copied state
    function automatic t_result table_step(t_item it);
        t_result             r;
        int                  idx, hit, n;
        logic [SAMPLE_W-1:0] smp, diff;
        r = '0;
        case (it.kind)
            KIND_CLEAR: begin
                for (n = 0; n < TABLE_SIZE; n++) begin
                    mdl_slot_tid[n] = '0;
                    mdl_slot_smp[n] = '0;
                end
                mdl_count = 0;
            end
            KIND_RECORD, KIND_CHECK: begin
                if (it.thread != mdl_cfg.own_thread && it.prio > mdl_cfg.min_prio) begin
                    // linear probe from the home slot
                    idx = it.thread % TABLE_SIZE;
                    hit = -1;
                    for (n = 0; n < TABLE_SIZE && hit < 0; n++) begin
                        if (mdl_slot_smp[idx] == '0 || mdl_slot_tid[idx] == it.thread)
                            hit = idx;
                        else
                            idx = (idx + 1) % TABLE_SIZE;
                    end
                    smp = it.cpu[SAMPLE_LSB +: SAMPLE_W];
                    if (smp == '0)
                        smp = SAMPLE_W'(1);
                    if (hit < 0) begin
                        r.table_full = 1'b1;
                    end else if (it.kind == KIND_RECORD) begin
                        mdl_slot_tid[hit] = it.thread;
                        mdl_slot_smp[hit] = smp;
                    end else if (mdl_slot_smp[hit] != '0) begin
                        diff = smp - mdl_slot_smp[hit];
                        if (diff > mdl_cfg.jump_thresh) begin
                            r.flagged = 1'b1;
                            if (mdl_count < LIST_DEPTH) begin
                                mdl_list_tid[mdl_count]  = it.thread;
                                mdl_list_prio[mdl_count] = it.prio;
                                mdl_list_team[mdl_count] = it.team;
                                mdl_count++;
                            end
                        end
                    end
                end
            end
            KIND_QUERY: begin
                for (n = 0; n < mdl_count; n++)
                    if (mdl_list_team[n] == it.team)
                        r.team_listed = 1'b1;
            end
            KIND_READ: begin
                if (it.eidx < mdl_count) begin
                    r.out_thread  = mdl_list_tid[it.eidx];
                    r.out_prio    = mdl_list_prio[it.eidx];
                    r.out_team    = mdl_list_team[it.eidx];
                    r.entry_valid = 1'b1;
                end
            end
            default: ;
        endcase
        r.count = mdl_count[CNT_W-1:0];
        return r;
    endfunction

    // random cpu time whose quantized sample is s
    function automatic logic [CPU_W-1:0] cpu_at(logic [SAMPLE_W-1:0] s);
        logic [CPU_W-1:0] c;
        c = CPU_W'({$urandom, $urandom});
        c[SAMPLE_LSB +: SAMPLE_W] = s;
        return c;
    endfunction

    task automatic add_item(input logic [KIND_W-1:0] k, input logic [TID_W-1:0] tid,
                            input logic [CPU_W-1:0] cpu, input logic [PRIO_W-1:0] pr,
                            input logic [TEAM_W-1:0] tm, input logic [EIDX_W-1:0] ei);
        t_step s;
        s = '0;
        s.sk        = STEP_ITEM;
        s.it.kind   = k;
        s.it.thread = tid;
        s.it.cpu    = cpu;
        s.it.prio   = pr;
        s.it.team   = tm;
        s.it.eidx   = ei;
        s.calm      = gen_calm;
        schedule.push_back(s);
    endtask

    task automatic add_cfg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] val);
        t_step s;
        s = '0;
        s.sk      = STEP_CFG;
        s.reg_idx = idx;
        s.reg_val = val;
        schedule.push_back(s);
        if (idx == CFG_MIN_PRIO)
            gen_min = val[PRIO_W-1:0];
    endtask

    task automatic add_drain();
        t_step s;
        s = '0;
        s.sk = STEP_DRAIN;
        schedule.push_back(s);
    endtask

    task automatic check_field(input string fname, input logic [63:0] want,
                               input logic [63:0] seen);
        if (want !== seen) begin
            $error("%s mismatch: expected %0d, got %0d", fname, want, seen);
            n_errors++;
        end
    endtask

    // input driver: items, register writes and drain pauses in schedule order
    always @(negedge i_clk) begin : feed
        logic                 v, we;
        logic [IN_DATA_W-1:0] d;
        t_step                st;
        int                   quiet;
        v  = 1'b0;
        we = 1'b0;
        if (!i_rst_n) begin
            quiet = 0;
        end else if (s_valid && n_accepted != n_presented) begin
            v = 1'b1;
        end else if (schedule.size() != 0) begin
            st = schedule[0];
            if (st.sk == STEP_ITEM) begin
                if (st.calm || $urandom_range(99, 0) >= IDLE_PCT) begin
                    st = schedule.pop_front();
                    d = '0;
                    d[IN_THREAD_LSB +: TID_W]  = st.it.thread;
                    d[IN_CPU_LSB    +: CPU_W]  = st.it.cpu;
                    d[IN_PRIO_LSB   +: PRIO_W] = st.it.prio;
                    d[IN_TEAM_LSB   +: TEAM_W] = st.it.team;
                    d[IN_EIDX_LSB   +: EIDX_W] = st.it.eidx;
                    v = 1'b1;
                    s_data   <= d;
                    s_kind   <= st.it.kind;
                    cur_item <= st.it;
                    calm_now <= st.calm;
                    n_presented++;
                end
            end else if (awaited.size() == 0) begin
                // block is idle: let it settle, then write or move on
                if (quiet < SETTLE) begin
                    quiet++;
                end else begin
                    quiet = 0;
                    st = schedule.pop_front();
                    if (st.sk == STEP_CFG) begin
                        we = 1'b1;
                        cfg_idx  <= st.reg_idx;
                        cfg_data <= st.reg_val;
                        case (st.reg_idx)
                            CFG_OWN_THREAD:  mdl_cfg.own_thread  = st.reg_val[TID_W-1:0];
                            CFG_MIN_PRIO:    mdl_cfg.min_prio    = st.reg_val[PRIO_W-1:0];
                            CFG_JUMP_THRESH: mdl_cfg.jump_thresh = st.reg_val[SAMPLE_W-1:0];
                            default: ;
                        endcase
                    end
                end
            end else begin
                quiet = 0;
            end
        end
        s_valid <= v;
        cfg_we  <= we;
    end

    // result sink backpressure
    always @(negedge i_clk) begin
        if (!i_rst_n)
            m_ready <= 1'b0;
        else
            m_ready <= calm_now || ($urandom_range(99, 0) >= IDLE_PCT);
    end

    // monitor: check results, then predict for newly accepted items
    always @(posedge i_clk) begin : watch
        logic [OUT_DATA_W-1:0] d;
        t_result               want;
        if (i_rst_n) begin
            if (m_valid && m_ready) begin
                d = m_data;
                if (awaited.size() == 0) begin
                    $error("result item with no prediction pending: %h", d);
                    n_errors++;
                end else begin
                    want = awaited.pop_front();
                    n_results++;
                    n_flag_seen += want.flagged;
                    n_full_seen += want.table_full;
                    n_team_hits += want.team_listed;
                    n_reads_ok  += want.entry_valid;
                    check_field("flagged", 64'(want.flagged), 64'(d[OUT_FLAGGED_LSB]));
                    check_field("table_full", 64'(want.table_full), 64'(d[OUT_FULL_LSB]));
                    check_field("team_listed", 64'(want.team_listed),
                                64'(d[OUT_LISTED_LSB]));
                    check_field("flagged_count", 64'(want.count),
                                64'(d[OUT_COUNT_LSB +: CNT_W]));
                    check_field("out_thread", 64'(want.out_thread),
                                64'(d[OUT_THREAD_LSB +: TID_W]));
                    check_field("out_priority", 64'(want.out_prio),
                                64'(d[OUT_PRIO_LSB +: PRIO_W]));
                    check_field("out_team", 64'(want.out_team),
                                64'(d[OUT_TEAM_LSB +: TEAM_W]));
                    check_field("entry_valid", 64'(want.entry_valid),
                                64'(d[OUT_EVALID_LSB]));
                end
            end
            if (s_valid && s_ready) begin
                awaited.push_back(table_step(cur_item));
                n_accepted++;
            end
        end
    end

    // run limit
    initial begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("Simulation FAILED");
        $finish;
    end

    initial begin : stim
        int                  i, k, p, r, n_items;
        logic [TID_W-1:0]    tid, own;
        logic [TEAM_W-1:0]   tm;
        logic [PRIO_W-1:0]   pr, mn;
        logic [SAMPLE_W-1:0] s, th, share;
        logic [TID_W-1:0]    pool_tid [POOL];
        logic [SAMPLE_W-1:0] pool_smp [POOL];
        logic [TEAM_W-1:0]   teams    [TEAMS];
        logic [TID_W-1:0]    fill_tid [TABLE_SIZE];
        logic [SAMPLE_W-1:0] fill_smp [TABLE_SIZE];

        for (i = 0; i < TABLE_SIZE; i++) begin
            mdl_slot_tid[i] = '0;
            mdl_slot_smp[i] = '0;
        end

        // directed: reset registers (own 0, min 10, threshold 25)
        add_item(KIND_READ, '0, '0, '0, '0, '0);
        add_item(KIND_QUERY, '0, '0, '0, '0, '0);
        add_item(KIND_RECORD, 31'd5, '0, 7'd127, '0, '0);                // zero sample
        add_item(KIND_CHECK, 31'd5, '1, 7'd127, '1, '1);                 // big jump
        add_item(KIND_CHECK, 31'd6, cpu_at(8'h40), 7'd11, '0, '0);       // absent
        add_item(KIND_RECORD, '0, cpu_at(8'h20), 7'd127, '0, '0);        // own thread
        add_item(KIND_RECORD, 31'd7, cpu_at(8'h10), 7'd10, '0, '0);      // prio at min
        add_item(KIND_RECORD, 31'd7, cpu_at(8'h10), 7'd11, '0, '0);
        add_item(KIND_RECORD, 31'd261, cpu_at(8'hF0), 7'd50, '0, '0);    // collides
        add_item(KIND_CHECK, 31'd261, cpu_at(8'h09), 7'd50, '0, '0);     // delta at limit
        add_item(KIND_CHECK, 31'd261, cpu_at(8'h0A), 7'd50, '0, '0);     // one above
        add_item(KIND_CHECK, 31'd7, cpu_at(8'h10), 7'd11, '0, '0);       // no change
        add_item(KIND_RECORD, '1, cpu_at(8'h80), 7'd127, '0, '0);
        add_item(KIND_CHECK, '1, cpu_at(8'h7F), 7'd127, 31'h5555_5555, '0);
        add_item(KIND_READ, '0, '0, '0, '0, 8'd0);
        add_item(KIND_READ, '0, '0, '0, '0, 8'd2);
        add_item(KIND_READ, '0, '0, '0, '0, 8'd3);                       // past count
        add_item(KIND_READ, '1, '1, '1, '1, '1);
        add_item(KIND_QUERY, '0, '0, '0, '1, '0);
        add_item(KIND_QUERY, '0, '0, '0, 31'h0001_2345, '0);
        add_item(KIND_SPARE, '1, '1, '1, '1, '1);
        add_item({KIND_W{1'b1}}, 31'd5, '1, '1, '1, '0);
        add_item(KIND_CLEAR, '1, '1, '1, '1, '1);
        add_item(KIND_READ, '0, '0, '0, '0, 8'd0);
        add_item(KIND_CHECK, 31'd5, '1, 7'd127, '0, '0);

        // fill the table and the list, register extremes
        add_cfg(CFG_OWN_THREAD, {TID_W{1'b1}});
        add_cfg(CFG_MIN_PRIO, '0);
        add_cfg(CFG_JUMP_THRESH, '0);
        for (k = 0; k < TEAMS; k++)
            teams[k] = TEAM_W'($urandom);
        add_item(KIND_CLEAR, TID_W'($urandom), '0, '0, '0, '0);
        for (i = 0; i < TABLE_SIZE; i++) begin
            fill_tid[i] = (TID_W'($urandom_range(32'h007F_FFFE, 0)) << SLOT_AW) | TID_W'(i);
            fill_smp[i] = SAMPLE_W'($urandom_range(255, 1));
            add_item(KIND_RECORD, fill_tid[i], cpu_at(fill_smp[i]),
                     PRIO_W'($urandom_range(127, 1)), TEAM_W'($urandom), EIDX_W'($urandom));
        end
        add_item(KIND_RECORD, 31'h7FFF_FF12, cpu_at(8'h33), 7'd99, '0, '0);   // no room
        add_item(KIND_CHECK, 31'h7FFF_FF12, cpu_at(8'hC3), 7'd99, '0, '0);
        for (i = 0; i < TABLE_SIZE + 2; i++) begin
            k = i % TABLE_SIZE;
            s = fill_smp[k] + SAMPLE_W'($urandom_range(254, 1));
            add_item(KIND_CHECK, fill_tid[k], cpu_at(s), PRIO_W'($urandom_range(127, 1)),
                     teams[$urandom_range(TEAMS - 1, 0)], EIDX_W'($urandom));
        end
        add_item(KIND_READ, '0, '0, '0, '0, '1);
        add_item(KIND_READ, '0, '0, '0, '0, '0);
        add_item(KIND_QUERY, '0, '0, '0, teams[0], '0);
        add_item(KIND_QUERY, '0, '0, '0, TEAM_W'($urandom), '0);

        // random phases: mostly record/check pairs on a small thread pool
        for (p = 0; p < 5; p++) begin
            share = SAMPLE_W'($urandom);
            for (k = 0; k < POOL; k++) begin
                pool_tid[k] = TID_W'($urandom);
                if (k < 6)
                    pool_tid[k][SLOT_AW-1:0] = share;
                pool_smp[k] = SAMPLE_W'($urandom_range(255, 1));
            end
            for (k = 0; k < TEAMS; k++)
                teams[k] = TEAM_W'($urandom);
            case (p)
                0: begin
                    own = TID_W'($urandom);
                    mn  = PRIO_W'($urandom_range(30, 0));
                    th  = SAMPLE_W'($urandom_range(60, 1));
                end
                1: begin
                    own = pool_tid[0];
                    mn  = '0;
                    th  = {SAMPLE_W{1'b1}};
                end
                2: begin
                    own = '0;
                    mn  = 7'd126;
                    th  = SAMPLE_W'($urandom_range(10, 0));
                end
                3: begin
                    own = {TID_W{1'b1}};
                    mn  = {PRIO_W{1'b1}};
                    th  = '0;
                end
                default: begin
                    own = OWN_THREAD_RST;
                    mn  = MIN_PRIO_RST;
                    th  = JUMP_THRESH_RST;
                end
            endcase
            add_cfg(CFG_OWN_THREAD, own);
            add_cfg(CFG_MIN_PRIO, CFG_DATA_W'(mn));
            add_cfg(CFG_JUMP_THRESH, CFG_DATA_W'(th));
            gen_calm = (p == 2);
            n_items = (p == 3) ? 40 : 140;
            if (p != 1)
                add_item(KIND_CLEAR, TID_W'($urandom), '0, '0, '0, '0);
            for (i = 0; i < n_items; i++) begin
                if (p == 0 && i == n_items / 2)
                    add_drain();
                k   = $urandom_range(POOL - 1, 0);
                tid = ($urandom_range(99, 0) < 90) ? pool_tid[k] : TID_W'($urandom);
                tm  = ($urandom_range(99, 0) < 85) ? teams[$urandom_range(TEAMS - 1, 0)]
                                                   : TEAM_W'($urandom);
                if (gen_min != {PRIO_W{1'b1}} && $urandom_range(99, 0) < 85)
                    pr = PRIO_W'($urandom_range(127, gen_min + 1));
                else
                    pr = PRIO_W'($urandom);
                r = $urandom_range(99, 0);
                if (r < 2) begin
                    add_item(KIND_CLEAR, tid, cpu_at(SAMPLE_W'($urandom)), pr, tm, '0);
                end else if (r < 38) begin
                    s = SAMPLE_W'($urandom);
                    pool_smp[k] = (s == '0) ? SAMPLE_W'(1) : s;
                    add_item(KIND_RECORD, tid, cpu_at(s), pr, tm, EIDX_W'($urandom));
                end else if (r < 74) begin
                    // mostly near the threshold so both verdicts show up
                    if ($urandom_range(99, 0) < 70)
                        s = pool_smp[k] + th + SAMPLE_W'($urandom_range(6, 0)) - SAMPLE_W'(3);
                    else
                        s = SAMPLE_W'($urandom);
                    add_item(KIND_CHECK, tid, cpu_at(s), pr, tm, EIDX_W'($urandom));
                end else if (r < 84) begin
                    add_item(KIND_QUERY, tid, cpu_at(SAMPLE_W'($urandom)), pr, tm, '0);
                end else if (r < 95) begin
                    add_item(KIND_READ, tid, '0, pr, tm,
                             ($urandom_range(99, 0) < 85) ? EIDX_W'($urandom_range(40, 0))
                                                          : EIDX_W'($urandom));
                end else begin
                    add_item(KIND_W'($urandom_range({KIND_W{1'b1}}, KIND_SPARE)), tid,
                             cpu_at(SAMPLE_W'($urandom)), pr, tm, EIDX_W'($urandom));
                end
            end
        end

        // reset, then wait for everything to drain
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        do
            @(negedge i_clk);
        while (!(schedule.size() == 0 && n_accepted == n_presented && awaited.size() == 0));
        repeat (TAIL) @(posedge i_clk);

        $display("run checked %0d result items: %0d flagged, %0d dropped on a full table",
                 n_results, n_flag_seen, n_full_seen);
        $display("%0d team query hits, %0d in-range list reads, %0d mismatches",
                 n_team_hits, n_reads_ok, n_errors);
        if (n_errors == 0 && awaited.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

>>> filelist.f
design/rtdt_pkg.sv
design/rtdt_slot_mem.sv
design/rtdt_list_mem.sv
design/rtdt_seq.sv
design/runaway_thread_detect_table.sv
design/rtdt_chk.sv
dv/runaway_thread_detect_table_tb.sv
